// ----- sv/dbcs_pkg.sv -----
// shared constants, codes and types for the double-byte charset converter
// no dependencies; imported by every module of the block but dbcs_ram
`default_nettype none

package dbcs_pkg;

    // code table geometry
    localparam int LEAD_ROWS  = 128;
    localparam int TRAIL_COLS = 256;
    localparam int TABLES     = 4;

    localparam int LEAD_W  = (LEAD_ROWS > 1) ? $clog2(LEAD_ROWS) : 1;
    localparam int TRAIL_W = (TRAIL_COLS > 1) ? $clog2(TRAIL_COLS) : 1;
    localparam int SEL_W   = 2;
    localparam int CODE_AW = SEL_W + LEAD_W + TRAIL_W;
    localparam int CODE_DEPTH = 1 << CODE_AW;
    localparam int CODE_W  = 16;

    // field widths
    localparam int BYTE_W   = 8;
    localparam int MODE_W   = 2;
    localparam int LIDX_W   = 7;
    localparam int TIDX_W   = 8;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 8;

    // input tdata bit positions
    localparam int SRC_LSB   = 0;
    localparam int SEL_LSB   = SRC_LSB + BYTE_W;
    localparam int LIDX_LSB  = SEL_LSB + SEL_W;
    localparam int TIDX_LSB  = LIDX_LSB + LIDX_W;
    localparam int ENTRY_LSB = TIDX_LSB + TIDX_W;

    // byte constants
    localparam logic [BYTE_W-1:0] LEAD_MIN  = 8'd128;
    localparam logic [BYTE_W-1:0] QMARK     = 8'h3F;
    localparam logic [BYTE_W-1:0] NUL       = 8'h00;

    // bounds as sized values for comparison
    localparam logic [LIDX_W:0] LEAD_ROWS_V  = (LIDX_W + 1)'(LEAD_ROWS);
    localparam logic [TIDX_W:0] TRAIL_COLS_V = (TIDX_W + 1)'(TRAIL_COLS);

    // configuration port
    localparam int CFG_AW = 2;
    localparam int CFG_DW = 32;
    localparam logic [CFG_AW-1:0] REG_MODE_ADDR = 2'd0;

    typedef enum logic {
        OP_CONVERT     = 1'b0,
        OP_TABLE_WRITE = 1'b1
    } op_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_BIG5_GBK = 2'd0,
        MODE_GBK_BIG5 = 2'd1,
        MODE_BIG5_UNI = 2'd2,
        MODE_GBK_UNI  = 2'd3
    } mode_t;

    // one decoded item waiting to be turned into output beats
    typedef struct packed {
        logic              lookup;  // bytes come from the table read data
        logic              two;     // two beats rather than one
        logic              eos;     // last beat ends the string
        logic [BYTE_W-1:0] b0;
        logic [BYTE_W-1:0] b1;
    } item_t;

endpackage

`default_nettype wire

// ----- sv/dbcs_ram.sv -----
// generic single-port ram with registered read data
// no dependencies
`default_nettype none

module dbcs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

`default_nettype wire

// ----- sv/dbcs_cfg.sv -----
// apb register block holding the conversion mode
// depends on dbcs_pkg
`default_nettype none

module dbcs_cfg (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [dbcs_pkg::CFG_AW-1:0]  paddr,
    input  wire logic [dbcs_pkg::CFG_DW-1:0]  pwdata,
    output logic      [dbcs_pkg::CFG_DW-1:0]  prdata,
    output logic                              pready,
    output dbcs_pkg::mode_t                   mode
);
    import dbcs_pkg::*;

    mode_t mode_reg;
    mode_t mode_next;
    logic  wr_mode;

    assign pready  = 1'b1;
    assign wr_mode = psel && penable && pwrite && pready && (paddr == REG_MODE_ADDR);

    always_comb
    begin
        mode_next = mode_reg;
        if (wr_mode)
        begin
            mode_next = mode_t'(pwdata[MODE_W-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_BIG5_GBK;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == REG_MODE_ADDR)
        begin
            prdata = {{(CFG_DW - MODE_W){1'b0}}, mode_reg};
        end
    end

    assign mode = mode_reg;

endmodule

`default_nettype wire

// ----- sv/dbcs_decode.sv -----
// input stage: clears the code tables after reset, tracks the pending lead byte,
// drives the table ram and registers one decoded item; depends on dbcs_pkg
`default_nettype none

module dbcs_decode (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [dbcs_pkg::IN_DATA_W-1:0] s_axis_tdata,
    input  wire logic                           s_axis_tuser,
    input  wire dbcs_pkg::mode_t                mode,
    input  wire logic                           item_take,
    output logic                                item_valid,
    output dbcs_pkg::item_t                     item,
    output logic                                ram_en,
    output logic                                ram_we,
    output logic      [dbcs_pkg::CODE_AW-1:0]   ram_addr,
    output logic      [dbcs_pkg::CODE_W-1:0]    ram_wdata
);
    import dbcs_pkg::*;

    logic               clr_active_reg, clr_active_next;
    logic [CODE_AW-1:0] clr_addr_reg, clr_addr_next;
    logic               pending_reg, pending_next;
    logic [BYTE_W-1:0]  held_reg, held_next;
    logic               item_valid_reg, item_valid_next;
    item_t              item_reg, item_next;

    op_t                op;
    logic [BYTE_W-1:0]  src;
    logic [SEL_W-1:0]   sel;
    logic [LIDX_W-1:0]  lidx;
    logic [TIDX_W-1:0]  tidx;
    logic [CODE_W-1:0]  entry;
    logic               accept;
    logic               uni;
    logic [BYTE_W-1:0]  held_row;
    logic               wr_in_range;
    logic               rd_in_range;

    assign op    = op_t'(s_axis_tuser);
    assign src   = s_axis_tdata[SRC_LSB +: BYTE_W];
    assign sel   = s_axis_tdata[SEL_LSB +: SEL_W];
    assign lidx  = s_axis_tdata[LIDX_LSB +: LIDX_W];
    assign tidx  = s_axis_tdata[TIDX_LSB +: TIDX_W];
    assign entry = s_axis_tdata[ENTRY_LSB +: CODE_W];

    assign s_axis_tready = !clr_active_reg && (!item_valid_reg || item_take);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign uni           = (mode == MODE_BIG5_UNI) || (mode == MODE_GBK_UNI);
    assign held_row      = held_reg - LEAD_MIN;

    assign wr_in_range = ({1'b0, lidx} < LEAD_ROWS_V) && ({1'b0, tidx} < TRAIL_COLS_V);
    assign rd_in_range = (held_row < LEAD_ROWS_V[BYTE_W-1:0]) && ({1'b0, src} < TRAIL_COLS_V);

    // clearing sweep, one entry a cycle
    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == CODE_AW'(CODE_DEPTH - 1))
            begin
                clr_active_next = 1'b0;
            end
        end
    end

    // byte decode and ram request
    always_comb
    begin
        pending_next    = pending_reg;
        held_next       = held_reg;
        item_valid_next = item_valid_reg && !item_take;
        item_next       = item_reg;
        ram_en          = 1'b0;
        ram_we          = 1'b0;
        ram_addr        = {sel, lidx[LEAD_W-1:0], tidx[TRAIL_W-1:0]};
        ram_wdata       = entry;

        if (clr_active_reg)
        begin
            ram_en    = 1'b1;
            ram_we    = 1'b1;
            ram_addr  = clr_addr_reg;
            ram_wdata = '0;
        end
        else if (accept)
        begin
            case (op)
                OP_TABLE_WRITE:
                begin
                    ram_en = wr_in_range;
                    ram_we = 1'b1;
                end
                OP_CONVERT:
                begin
                    item_next.lookup = 1'b0;
                    item_next.two    = 1'b0;
                    item_next.eos    = 1'b0;
                    item_next.b0     = src;
                    item_next.b1     = NUL;
                    if (pending_reg)
                    begin
                        pending_next    = 1'b0;
                        item_valid_next = 1'b1;
                        item_next.two   = 1'b1;
                        if (src == NUL)
                        begin
                            // dangling lead byte at end of string
                            item_next.b0  = QMARK;
                            item_next.eos = 1'b1;
                        end
                        else
                        begin
                            item_next.b0     = QMARK;
                            item_next.b1     = QMARK;
                            item_next.lookup = rd_in_range;
                            ram_en           = rd_in_range;
                            ram_addr         = {mode, held_row[LEAD_W-1:0],
                                                src[TRAIL_W-1:0]};
                        end
                    end
                    else if (src == NUL)
                    begin
                        item_valid_next = 1'b1;
                        item_next.two   = uni;
                        item_next.eos   = 1'b1;
                    end
                    else if (src < LEAD_MIN)
                    begin
                        item_valid_next = 1'b1;
                        item_next.two   = uni;
                    end
                    else
                    begin
                        pending_next = 1'b1;
                        held_next    = src;
                    end
                end
                default:
                begin
                    ram_en = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            pending_reg    <= 1'b0;
            held_reg       <= '0;
            item_valid_reg <= 1'b0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
            pending_reg    <= pending_next;
            held_reg       <= held_next;
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign item_valid = item_valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// ----- sv/dbcs_emit.sv -----
// output stage: resolves table read data and serialises up to two bytes per item
// depends on dbcs_pkg
`default_nettype none

module dbcs_emit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            item_valid,
    input  wire dbcs_pkg::item_t                 item,
    input  wire logic [dbcs_pkg::CODE_W-1:0]     rdata,
    output logic                                 item_take,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic      [dbcs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic                                 m_axis_tlast
);
    import dbcs_pkg::*;

    logic [1:0]        cnt_reg, cnt_next;
    logic [BYTE_W-1:0] b0_reg, b0_next;
    logic [BYTE_W-1:0] b1_reg, b1_next;
    logic              eos_reg, eos_next;
    logic              m_fire;
    logic              load;
    logic              hit;

    assign m_axis_tvalid = (cnt_reg != 2'd0);
    assign m_fire        = m_axis_tvalid && m_axis_tready;
    assign load          = item_valid && ((cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_fire));
    assign item_take     = load;
    assign hit           = (rdata != '0);

    always_comb
    begin
        cnt_next = cnt_reg;
        b0_next  = b0_reg;
        b1_next  = b1_reg;
        eos_next = eos_reg;
        if (load)
        begin
            cnt_next = item.two ? 2'd2 : 2'd1;
            eos_next = item.eos;
            b0_next  = item.b0;
            b1_next  = item.b1;
            if (item.lookup && hit)
            begin
                b0_next = rdata[BYTE_W-1:0];
                b1_next = rdata[CODE_W-1:BYTE_W];
            end
        end
        else if (m_fire)
        begin
            cnt_next = cnt_reg - 2'd1;
            b0_next  = b1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b0_reg  <= b0_next;
        b1_reg  <= b1_next;
        eos_reg <= eos_next;
    end

    assign m_axis_tdata = b0_reg;
    assign m_axis_tlast = (cnt_reg == 2'd1) && eos_reg;

endmodule

`default_nettype wire

// ----- sv/dbcs_charset_converter_top.sv -----
// path: an accepted source beat is registered as an item, then loaded for output
// throughput: one source beat per cycle while the output keeps up; one byte per
//   output beat, so pairs, unicode ascii and unicode terminators take two beats
// reset: after rst_n the 131072-entry code table is swept to zero, one entry a cycle,
//   with s_axis_tready low until the sweep ends; apb writes are taken throughout
`default_nettype none

module dbcs_charset_converter_top (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // input stream
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // source_byte[7:0], table_select[9:8], lead_index[16:10],
    // trail_index[24:17], entry_value[40:25], zero fill above
    input  wire logic [dbcs_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // operation[0]
    input  wire logic                                s_axis_tuser,
    // output stream
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // out_byte[7:0]
    output logic      [dbcs_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // end_of_string
    output logic                                     m_axis_tlast,
    // configuration
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [dbcs_pkg::CFG_AW-1:0]         paddr,
    input  wire logic [dbcs_pkg::CFG_DW-1:0]         pwdata,
    output logic      [dbcs_pkg::CFG_DW-1:0]         prdata,
    output logic                                     pready
);
    import dbcs_pkg::*;

    mode_t              mode;
    logic               item_valid;
    item_t              item;
    logic               item_take;
    logic               ram_en;
    logic               ram_we;
    logic [CODE_AW-1:0] ram_addr;
    logic [CODE_W-1:0]  ram_wdata;
    logic [CODE_W-1:0]  ram_rdata;

    // conversion mode register
    dbcs_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .mode    (mode)
    );

    // input beat decode, lead byte tracking, table access and clearing sweep
    dbcs_decode u_decode (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .mode          (mode),
        .item_take     (item_take),
        .item_valid    (item_valid),
        .item          (item),
        .ram_en        (ram_en),
        .ram_we        (ram_we),
        .ram_addr      (ram_addr),
        .ram_wdata     (ram_wdata)
    );

    // all four code tables in one memory, addressed {table, lead row, trail}
    dbcs_ram #(
        .WIDTH (CODE_W),
        .DEPTH (CODE_DEPTH)
    ) u_tables (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // read data arrives together with the registered item; unmapped gives '??'
    dbcs_emit u_emit (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item          (item),
        .rdata         (ram_rdata),
        .item_take     (item_take),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

// ----- tb/sv/tb_dbcs_charset_converter_top.sv -----
// self-checking testbench for dbcs_charset_converter_top: stream driver, stream monitor, apb writes
// predicts every output byte from its own copy of the code tables and the pending lead byte
// depends on dbcs_pkg and dbcs_charset_converter_top
`timescale 1ns / 100ps

module tb_dbcs_charset_converter_top;

    import dbcs_pkg::*;

    // one source beat as the stimulus sees it
    typedef struct {
        op_t               op;
        logic [BYTE_W-1:0] src;
        logic [SEL_W-1:0]  sel;
        logic [LIDX_W-1:0] lead;
        logic [TIDX_W-1:0] trail;
        logic [CODE_W-1:0] entry;
    } source_beat_t;

    // one output byte as predicted
    typedef struct {
        logic [BYTE_W-1:0] value;
        logic              last;
    } out_beat_t;

    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 154;   // about 1230 random beats over all phases
    localparam int HOLD_CYCLES = 400;   // long receiver hold-off, fills the block
    localparam int SETTLE      = 8;     // settling margin after the block looks idle

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [CFG_AW-1:0]     paddr   = '0;
    logic [CFG_DW-1:0]     pwdata  = '0;
    logic [CFG_DW-1:0]     prdata;
    logic                  pready;

    // stimulus and scoreboard state
    source_beat_t      source_queue [$];
    source_beat_t      offered_beat;
    out_beat_t         expected_bytes [$];
    out_beat_t         wanted;
    logic [CODE_W-1:0] code_map [int];     // sparse copy of the four tables, absent means zero
    mode_t             active_mode = MODE_BIG5_GBK;
    logic              lead_held   = 1'b0;
    logic [BYTE_W-1:0] held_byte   = '0;
    int                fail_count  = 0;
    int                beats_queued = 0;

    // idling controls, changed by the stimulus between phases
    int                src_idle_pct = 0;
    int                rx_stall_pct = 0;
    logic              rx_hold_arm  = 1'b0;
    int                rx_hold_left = 0;

    mode_t phase_modes [PHASES] = '{MODE_BIG5_GBK, MODE_GBK_BIG5, MODE_BIG5_UNI, MODE_GBK_UNI,
                                    MODE_GBK_UNI, MODE_BIG5_UNI, MODE_GBK_BIG5, MODE_BIG5_GBK};

    dbcs_charset_converter_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // works out the output bytes of one accepted beat and updates the shadow state
    task automatic predict_conversion(input source_beat_t it);
        logic [CODE_W-1:0] code;
        int                key;
        logic              wide;
        wide = (active_mode == MODE_BIG5_UNI) || (active_mode == MODE_GBK_UNI);
        if (it.op == OP_TABLE_WRITE)
        begin
            // a table write never touches the pending lead
            if (int'(it.lead) < LEAD_ROWS && int'(it.trail) < TRAIL_COLS)
                code_map[int'({it.sel, it.lead, it.trail})] = it.entry;
            return;
        end
        if (lead_held)
        begin
            lead_held = 1'b0;
            if (it.src == NUL)
            begin
                // lead cut short by the terminator
                expected_bytes.push_back('{QMARK, 1'b0});
                expected_bytes.push_back('{NUL, 1'b1});
                return;
            end
            // the table follows the mode at the moment the trail byte arrives
            key  = int'({active_mode, held_byte[6:0], it.src});
            code = code_map.exists(key) ? code_map[key] : '0;
            if (int'(held_byte[6:0]) >= LEAD_ROWS || int'(it.src) >= TRAIL_COLS)
                code = '0;
            if (code != '0)
            begin
                expected_bytes.push_back('{code[7:0], 1'b0});
                expected_bytes.push_back('{code[15:8], 1'b0});
            end
            else
            begin
                expected_bytes.push_back('{QMARK, 1'b0});
                expected_bytes.push_back('{QMARK, 1'b0});
            end
            return;
        end
        if (it.src == NUL)
        begin
            if (wide)
                expected_bytes.push_back('{NUL, 1'b0});
            expected_bytes.push_back('{NUL, 1'b1});
        end
        else if (it.src < LEAD_MIN)
        begin
            expected_bytes.push_back('{it.src, 1'b0});
            if (wide)
                expected_bytes.push_back('{NUL, 1'b0});
        end
        else
        begin
            // lead byte: held, nothing out yet
            lead_held = 1'b1;
            held_byte = it.src;
        end
    endtask

    function automatic source_beat_t convert_beat(input logic [BYTE_W-1:0] b);
        source_beat_t it;
        it = '{OP_CONVERT, b, SEL_W'($urandom), LIDX_W'($urandom), TIDX_W'($urandom),
               CODE_W'($urandom)};
        return it;
    endfunction

    function automatic source_beat_t table_write_beat(input logic [SEL_W-1:0] sel,
                                                      input logic [LIDX_W-1:0] lead,
                                                      input logic [TIDX_W-1:0] trail,
                                                      input logic [CODE_W-1:0] entry);
        source_beat_t it;
        it = '{OP_TABLE_WRITE, BYTE_W'($urandom), sel, lead, trail, entry};
        return it;
    endfunction

    // mostly a few hot rows at both ends of the range, so reads hit written entries
    function automatic logic [LIDX_W-1:0] pick_lead();
        logic [2:0] r;
        if ($urandom_range(99) < 70)
        begin
            r = 3'($urandom_range(7));
            return r[2] ? LIDX_W'(124 + r[1:0]) : LIDX_W'(r[1:0]);
        end
        return LIDX_W'($urandom_range(127));
    endfunction

    function automatic logic [TIDX_W-1:0] pick_trail();
        logic [2:0] r;
        if ($urandom_range(99) < 70)
        begin
            r = 3'($urandom_range(7));
            return r[2] ? TIDX_W'(252 + r[1:0]) : TIDX_W'(1 + r[1:0]);
        end
        return TIDX_W'($urandom_range(1, 255));
    endfunction

    task automatic enqueue_beat(input source_beat_t it);
        source_queue.push_back(it);
        beats_queued++;
    endtask

    // one well-formed string with random content, now and then broken or noisy
    task automatic queue_random_string();
        int               n;
        int               r;
        logic [SEL_W-1:0] sel;
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < 15)
            begin
                sel = ($urandom_range(99) < 70) ? SEL_W'(active_mode) : SEL_W'($urandom);
                enqueue_beat(table_write_beat(sel, pick_lead(), pick_trail(),
                    ($urandom_range(9) == 0) ? CODE_W'(0) : CODE_W'($urandom)));
            end
            else if (r < 45)
                enqueue_beat(convert_beat(BYTE_W'($urandom_range(1, 127))));
            else if (r < 88)
            begin
                enqueue_beat(convert_beat({1'b1, pick_lead()}));
                enqueue_beat(convert_beat(pick_trail()));
            end
            else
            begin
                // noise: any field, any operation
                enqueue_beat('{op_t'($urandom_range(1)), BYTE_W'($urandom), SEL_W'($urandom),
                               LIDX_W'($urandom), TIDX_W'($urandom), CODE_W'($urandom)});
            end
        end
        r = $urandom_range(99);
        if (r < 10)
        begin
            enqueue_beat(convert_beat({1'b1, pick_lead()}));
            enqueue_beat(convert_beat(NUL));
        end
        else if (r < 95)
            enqueue_beat(convert_beat(NUL));
    endtask

    // block idle: nothing queued, nothing offered, nothing owed, then let a lead byte settle
    task automatic wait_idle();
        while (source_queue.size() != 0 || s_axis_tvalid || expected_bytes.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // apb write of the mode register: setup cycle, then access cycle
    task automatic write_mode(input mode_t m);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_MODE_ADDR;
        pwdata  <= CFG_DW'(m);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        active_mode = m;
        @(negedge clk);
    endtask

    // source side: predict on acceptance, then offer the next beat or idle
    always @(posedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                predict_conversion(offered_beat);
            // a beat on offer is held until taken
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (source_queue.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    offered_beat = source_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= offered_beat.op;
                    s_axis_tdata  <= {7'd0, offered_beat.entry, offered_beat.trail,
                                      offered_beat.lead, offered_beat.sel, offered_beat.src};
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, counted down on its own
    always @(posedge clk)
    begin
        if (rx_hold_arm)
            rx_hold_left <= HOLD_CYCLES;
        else if (rx_hold_left != 0)
            rx_hold_left <= rx_hold_left - 1;
    end

    // result side: compare each accepted byte with the oldest prediction
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $error("out_byte %0h with no prediction waiting", m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    wanted = expected_bytes.pop_front();
                    if (m_axis_tdata !== wanted.value)
                    begin
                        $error("out_byte: expected %0h, got %0h", wanted.value, m_axis_tdata);
                        fail_count++;
                    end
                    if (m_axis_tlast !== wanted.last)
                    begin
                        $error("end_of_string: expected %0b, got %0b", wanted.last,
                               m_axis_tlast);
                        fail_count++;
                    end
                end
            end
            m_axis_tready <= (rx_hold_left == 0) && ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // reset once, then directed beats, then the random phases
    initial
    begin
        int phase_start;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        // register writes are taken while the tables are being cleared
        write_mode(MODE_BIG5_GBK);

        // directed part in big5 to gbk: field extremes, mapped and unmapped pairs
        enqueue_beat(table_write_beat(2'd0, 7'd0, 8'd1, 16'hFFFF));
        enqueue_beat(table_write_beat(2'd0, 7'd127, 8'd255, 16'h0001));
        enqueue_beat(table_write_beat(2'd3, 7'd127, 8'd255, 16'hA5C3));
        enqueue_beat(table_write_beat(2'd1, 7'd127, 8'd255, 16'h5A3C));
        enqueue_beat(convert_beat(8'h41));
        enqueue_beat(convert_beat(8'h7F));
        enqueue_beat(convert_beat(8'h80));
        enqueue_beat(convert_beat(8'h01));
        enqueue_beat(convert_beat(8'hFF));
        // table write while a lead is pending leaves the lead alone
        enqueue_beat(table_write_beat(2'd2, 7'd5, 8'd5, 16'h1234));
        enqueue_beat(convert_beat(8'hFF));
        enqueue_beat(convert_beat(8'h90));
        enqueue_beat(convert_beat(8'h30));
        // lead cut short by the terminator, then a plain terminator
        enqueue_beat(convert_beat(8'h85));
        enqueue_beat(convert_beat(NUL));
        enqueue_beat(convert_beat(NUL));
        // writing zero unmaps an entry again
        enqueue_beat(table_write_beat(2'd0, 7'd0, 8'd1, 16'h0000));
        enqueue_beat(convert_beat(8'h80));
        enqueue_beat(convert_beat(8'h01));
        wait_idle();

        // unicode mode: ascii widened, two-byte terminator
        write_mode(MODE_GBK_UNI);
        enqueue_beat(convert_beat(8'h41));
        enqueue_beat(convert_beat(8'hFF));
        enqueue_beat(convert_beat(8'hFF));
        enqueue_beat(convert_beat(NUL));
        enqueue_beat(convert_beat(8'hFF));
        wait_idle();
        // mode changed between lead and trail: the trail picks the table
        write_mode(MODE_GBK_BIG5);
        enqueue_beat(convert_beat(8'hFF));
        wait_idle();

        for (int p = 0; p < PHASES; p++)
        begin
            write_mode(phase_modes[p]);
            case (p % 4)
                0:       begin src_idle_pct = 0;  rx_stall_pct = 0;  end
                1:       begin src_idle_pct = 55; rx_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  rx_stall_pct = 55; end
                default: begin src_idle_pct = 25; rx_stall_pct = 25; end
            endcase
            phase_start = beats_queued;
            while (beats_queued - phase_start < PHASE_ITEMS / 2)
                queue_random_string();
            if (p == 0)
            begin
                // receiver holds off while the sender keeps offering
                rx_hold_arm = 1'b1;
                @(negedge clk);
                rx_hold_arm = 1'b0;
            end
            else if (p == 4)
                wait_idle();   // sender pauses until every byte owed has come out
            while (beats_queued - phase_start < PHASE_ITEMS)
                queue_random_string();
            wait_idle();
        end

        if (fail_count == 0)
            $display("dbcs_charset_converter_top verification clean");
        else
            $display("dbcs_charset_converter_top verification failed");
        $finish;
    end

    // overall limit: clearing pass plus a generous margin for the stalled phases
    initial
    begin
        #(20_000_000);
        $display("dbcs_charset_converter_top verification failed");
        $finish;
    end

endmodule
